// File: hw/rtl/isidl_pkg.sv
// Shared types and constants for the indexed shift insert/delete list.
// Used by isidl_cell and indexed_shift_insert_delete_list; no dependencies.

package isidl_pkg;

  // Default sizes of the list storage.
  localparam int unsigned DEF_DEPTH = 64;
  localparam int unsigned DEF_WIDTH = 32;

  // Fixed field widths on the streaming ports.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned ITEM_W   = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  // Packed payload widths, rounded up to whole bytes.
  localparam int unsigned IN_BITS  = OP_W + POS_W + ITEM_W;
  localparam int unsigned OUT_BITS = DATA_W + COUNT_W + STATUS_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Shift command broadcast to every cell of the row.
  typedef struct packed {
    logic ins;  // open a gap at the position and write the new word there
    logic del;  // close the gap left by the word at the position
  } cell_ctl_t;

endpackage

// File: hw/rtl/isidl_cell.sv
// One storage cell of the list row: holds a single entry and trades it with
// its neighbors on insert and delete. Depends on isidl_pkg.

module isidl_cell import isidl_pkg::*; #(
  parameter int unsigned WIDTH = DEF_WIDTH,
  parameter int unsigned CW    = POS_W
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CW-1:0]    idx,
  input  logic [CW-1:0]    pos,
  input  logic [WIDTH-1:0] item,
  input  logic [WIDTH-1:0] left_q,
  input  logic [WIDTH-1:0] right_q,
  output logic [WIDTH-1:0] q,
  output logic [WIDTH-1:0] rd_q
);

  logic [WIDTH-1:0] q_r;
  logic [WIDTH-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctl.ins) begin
      if (idx == pos) begin
        q_nxt = item;
      end else if (idx > pos) begin
        q_nxt = left_q;
      end
    end else if (ctl.del) begin
      if (idx >= pos) begin
        q_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q    = q_r;
  // Only the addressed cell drives its word onto the read bus.
  assign rd_q = (idx == pos) ? q_r : '0;

endmodule

// File: hw/rtl/indexed_shift_insert_delete_list.sv
// Top level of the indexed shift insert/delete list: a row of isidl_cell
// storage cells, the fill counter, request decode and the result register.
// Depends on isidl_pkg and isidl_cell.
//
//  Channel  Direction  Handshake              Payload
//  in_      slave      in_tvalid/in_tready    in_tdata: op, position, item
//  out_     master     out_tvalid/out_tready  out_tdata: data, count, status
//
// When a request is accepted, the whole cell row shifts at once on that edge,
// and the result appears in the output register on the next cycle, so one
// request per cycle is sustained while out_tready stays high. The single
// output register sets the rate: a new request is taken whenever that
// register is empty or is being emptied in the same cycle. Reset (rst_n
// low, synchronous) empties the list and the output register; the cell
// contents are not cleared because only filled entries can ever be read.
// While out_tready is low with a result held, in_tready drops and the list
// state is frozen.

module indexed_shift_insert_delete_list import isidl_pkg::*; #(
  parameter int unsigned DEPTH = DEF_DEPTH,
  parameter int unsigned WIDTH = DEF_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata, from bit 0 up: op[1:0], position[7:2], item[39:8]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata, from bit 0 up: data[31:0], count[38:32], status[40:39], zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // The fill counter must hold DEPTH itself; position compares are done at a
  // width that covers both the counter and the position field.
  localparam int unsigned IW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (IW > POS_W) ? IW : POS_W;

  // Unpacked request fields.
  op_t               req_op;
  logic [POS_W-1:0]  req_pos;
  logic [ITEM_W-1:0] req_item;

  assign req_op   = op_t'(in_tdata[OP_W-1:0]);
  assign req_pos  = in_tdata[OP_W +: POS_W];
  assign req_item = in_tdata[OP_W+POS_W +: ITEM_W];

  // List occupancy and result register.
  logic [IW-1:0]       fill_r;
  logic [IW-1:0]       fill_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r;
  logic [DATA_W-1:0]   out_data_nxt;
  logic [COUNT_W-1:0]  out_count_r;
  logic [COUNT_W-1:0]  out_count_nxt;
  status_t             out_status_r;
  status_t             out_status_nxt;

  logic                in_acc;
  logic [CW-1:0]       pos_ext;
  logic [CW-1:0]       fill_ext;
  logic                full;
  logic                ins_ok;
  logic                pos_in_list;
  cell_ctl_t           ctl;
  logic [WIDTH-1:0]    word;
  logic [WIDTH+ITEM_W-1:0] item_ext;
  logic [WIDTH-1:0]    rd_word;
  logic [WIDTH+DATA_W-1:0] rd_ext;
  logic [IW+COUNT_W-1:0]   count_ext;

  // Accept whenever the result register is free or drains this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign pos_ext     = CW'(req_pos);
  assign fill_ext    = CW'(fill_r);
  assign full        = (fill_r == IW'(DEPTH));
  assign ins_ok      = !full && (pos_ext <= fill_ext);
  assign pos_in_list = (pos_ext < fill_ext);

  // Only the low WIDTH bits of an inserted word are kept.
  assign item_ext = {{WIDTH{1'b0}}, req_item};
  assign word     = item_ext[WIDTH-1:0];

  // Shift commands are raised only for requests that will succeed, so a
  // rejected request leaves the row untouched.
  always_comb begin
    ctl.ins = in_acc && (req_op == OP_INSERT) && ins_ok;
    ctl.del = in_acc && (req_op == OP_DELETE) && pos_in_list;
  end

  // Row of cells. Cell 0 has no left neighbor and the last cell no right
  // neighbor; those inputs are never selected for a valid shift that matters.
  logic [WIDTH-1:0] cell_q  [DEPTH];
  logic [WIDTH-1:0] cell_rd [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left_q;
    logic [WIDTH-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_left
      assign left_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_right
      assign right_q = cell_q[i+1];
    end

    isidl_cell #(
      .WIDTH (WIDTH),
      .CW    (CW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (CW'(i)),
      .pos     (pos_ext),
      .item    (word),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i]),
      .rd_q    (cell_rd[i])
    );
  end

  // At most one cell matches the position, so an OR across the row selects
  // the addressed word.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  assign rd_ext = {{DATA_W{1'b0}}, rd_word};

  // Request decode: new occupancy and the result fields.
  always_comb begin
    fill_nxt       = fill_r;
    out_data_nxt   = '0;
    out_status_nxt = ST_DONE;
    case (req_op)
      OP_INSERT: begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else if (!ins_ok) begin
          out_status_nxt = ST_RANGE;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      OP_DELETE: begin
        if (!pos_in_list) begin
          out_status_nxt = ST_RANGE;
        end else begin
          out_data_nxt = rd_ext[DATA_W-1:0];
          fill_nxt     = fill_r - 1'b1;
        end
      end
      OP_READ: begin
        if (!pos_in_list) begin
          out_status_nxt = ST_RANGE;
        end else begin
          out_data_nxt = rd_ext[DATA_W-1:0];
        end
      end
      default: begin
        // No-operation code: no change, report the current count.
      end
    endcase
    count_ext     = {{COUNT_W{1'b0}}, fill_nxt};
    out_count_nxt = count_ext[COUNT_W-1:0];
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        fill_r <= fill_nxt;
      end
    end
  end

  // Result payload; loaded only when a request is accepted.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r   <= out_data_nxt;
      out_count_r  <= out_count_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_status_r, out_count_r,
                       out_data_r};

  // The list never holds more than DEPTH entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= IW'(DEPTH))
    else $error("fill count exceeds list depth");

  // A successful insert grows the list by exactly one entry.
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> fill_r == $past(fill_r) + 1'b1)
    else $error("insert did not grow the list by one");

  // A successful delete shrinks the list by exactly one entry.
  a_del_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.del |=> fill_r == $past(fill_r) - 1'b1)
    else $error("delete did not shrink the list by one");

  // Every accepted request produces a result on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request produced no result");

  // A rejected request never returns a word.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_DONE) |-> out_data_r == '0)
    else $error("rejected request returned data");

  // Inserts and deletes are never commanded together.
  a_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.ins && ctl.del))
    else $error("insert and delete commanded together");

endmodule
